// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/tzsf_pkg.sv =====
// ----------------------------------------------------------------------------
// tzsf_pkg
// Types, constants and helpers shared by the TZif section framer.
// ----------------------------------------------------------------------------
`default_nettype none

package tzsf_pkg;

  // Largest count value accepted, in bits (range 8..32).
  localparam int COUNT_BITS = 32;
  // Stored count width: counts always arrive as four bytes.
  localparam int CNT_W      = 32;
  // Section length width: twelve times a 32-bit count.
  localparam int SIZE_W     = 36;
  localparam int NUM_COUNTS = 6;

  // Fixed header section lengths.
  localparam logic [SIZE_W-1:0] MAGIC_LEN    = SIZE_W'(4);
  localparam logic [SIZE_W-1:0] VERSION_LEN  = SIZE_W'(1);
  localparam logic [SIZE_W-1:0] RESERVED_LEN = SIZE_W'(15);
  localparam logic [SIZE_W-1:0] COUNTS_LEN   = SIZE_W'(24);
  localparam logic [4:0]        COUNTS_BYTES = 5'd24;

  // Count slots, in file order.
  localparam int CI_UTC    = 0;
  localparam int CI_STD    = 1;
  localparam int CI_LEAP   = 2;
  localparam int CI_TIME   = 3;
  localparam int CI_TYPE   = 4;
  localparam int CI_CHAR   = 5;

  // Version bytes that are accepted.
  localparam logic [7:0] VER_V1 = 8'h00;
  localparam logic [7:0] VER_V2 = 8'h32;
  localparam logic [7:0] VER_V3 = 8'h33;
  localparam logic [7:0] VER_V4 = 8'h34;

  typedef enum logic [3:0] {
    PH_MAGIC    = 4'd0,
    PH_VERSION  = 4'd1,
    PH_RESERVED = 4'd2,
    PH_COUNTS   = 4'd3,
    PH_TIMES    = 4'd4,
    PH_INDICES  = 4'd5,
    PH_TYPES    = 4'd6,
    PH_ABBREV   = 4'd7,
    PH_LEAPS    = 4'd8,
    PH_STD      = 4'd9,
    PH_UTC      = 4'd10,
    PH_TRAILING = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    ST_RUNNING     = 3'd0,
    ST_COMPLETE    = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_TRUNCATED   = 3'd4
  } status_t;

  typedef logic [CNT_W-1:0] count_t;

  // One result item.
  typedef struct packed {
    logic [7:0] byte_out;
    logic [3:0] section;
    logic       second_block;
    logic       section_end;
    logic [2:0] status;
  } result_t;

  // Expected magic byte at a given position of "TZif".
  function automatic logic [7:0] magic_char(input logic [1:0] idx);
    case (idx)
      2'd0:    magic_char = 8'h54;
      2'd1:    magic_char = 8'h5A;
      2'd2:    magic_char = 8'h69;
      default: magic_char = 8'h66;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== src/tzsf_core.sv =====
// ----------------------------------------------------------------------------
// tzsf_core
// Framing state and per-byte decode; produces one result item per step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tzsf_core import tzsf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step,
  input  wire logic [7:0] data_byte,
  input  wire logic    end_of_file,
  output result_t      res
);

  phase_t              phase_r, phase_nxt;
  logic                block_r, block_nxt;
  logic [7:0]          ver_r, ver_nxt;
  logic [SIZE_W-1:0]   rem_r, rem_nxt;
  count_t              counts_r [NUM_COUNTS];
  count_t              counts_nxt [NUM_COUNTS];
  status_t             fstat_r, fstat_nxt;

  // Body section length from the counts.
  function automatic logic [SIZE_W-1:0] body_size(input phase_t ph, input count_t t,
      input count_t ty, input count_t ch, input count_t lp, input count_t sd,
      input count_t ut, input logic blk);
    logic [SIZE_W-1:0] w;
    begin
      w = SIZE_W'(0);
      case (ph)
        PH_TIMES:   w = blk ? {1'b0, t, 3'b000} : {2'b00, t, 2'b00};
        PH_INDICES: w = SIZE_W'(t);
        PH_TYPES:   w = SIZE_W'({t[0] & 1'b0, ty, 2'b00}) + SIZE_W'({ty, 1'b0}) -
                        SIZE_W'({t[0] & 1'b0, ty, 2'b00}) + SIZE_W'({ty, 2'b00});
        PH_ABBREV:  w = SIZE_W'(ch);
        PH_LEAPS:   w = blk ? (SIZE_W'({lp, 3'b000}) + SIZE_W'({lp, 2'b00}))
                            : SIZE_W'({lp, 3'b000});
        PH_STD:     w = SIZE_W'(sd);
        PH_UTC:     w = SIZE_W'(ut);
        default:    w = SIZE_W'(0);
      endcase
      body_size = w;
    end
  endfunction

  logic [4:0]        cpos;
  logic [2:0]        cidx;
  logic              failed;
  logic              fits;
  logic              found;
  logic [SIZE_W-1:0] sz;
  status_t           st;

  always_comb begin
    phase_nxt = phase_r;
    block_nxt = block_r;
    ver_nxt   = ver_r;
    rem_nxt   = rem_r;
    fstat_nxt = fstat_r;
    for (int i = 0; i < NUM_COUNTS; i++) counts_nxt[i] = counts_r[i];
    failed = 1'b0;
    fits   = 1'b1;
    found  = 1'b0;
    sz     = SIZE_W'(0);
    st     = ST_RUNNING;
    cpos   = COUNTS_BYTES - rem_r[4:0];
    cidx   = cpos[4:2];

    res.byte_out     = data_byte;
    res.second_block = block_r;
    res.section      = phase_r;
    res.section_end  = 1'b0;

    if (phase_r >= PH_TRAILING) begin
      res.section = PH_TRAILING;
      st          = fstat_r;
    end else begin
      // Byte checks and count capture
      case (phase_r)
        PH_MAGIC: begin
          if (data_byte != magic_char(2'(-rem_r[1:0]))) begin
            failed = 1'b1;
            st     = ST_BAD_MAGIC;
          end
        end
        PH_VERSION: begin
          ver_nxt = data_byte;
          if (data_byte != VER_V1 && data_byte != VER_V2 &&
              data_byte != VER_V3 && data_byte != VER_V4) begin
            failed = 1'b1;
            st     = ST_BAD_VERSION;
          end
        end
        PH_COUNTS: begin
          for (int i = 0; i < NUM_COUNTS; i++) begin
            if (cidx == 3'(i)) begin
              if (cpos[1:0] == 2'd0) counts_nxt[i] = CNT_W'(data_byte);
              else counts_nxt[i] = {counts_r[i][CNT_W-9:0], data_byte};
            end
          end
        end
        default: ;
      endcase

      if (failed) begin
        res.section_end = 1'b1;
        phase_nxt       = PH_TRAILING;
        fstat_nxt       = st;
      end else if (rem_r <= SIZE_W'(1)) begin
        // Section done: move on to the next non-empty section, the second block, or trailing
        res.section_end = 1'b1;
        for (int i = 0; i < NUM_COUNTS; i++) begin
          if ((counts_nxt[i] >> COUNT_BITS) != count_t'(0)) fits = 1'b0;
        end
        case (phase_r)
          PH_MAGIC: begin
            phase_nxt = PH_VERSION;
            rem_nxt   = VERSION_LEN;
          end
          PH_VERSION: begin
            phase_nxt = PH_RESERVED;
            rem_nxt   = RESERVED_LEN;
          end
          PH_RESERVED: begin
            phase_nxt = PH_COUNTS;
            rem_nxt   = COUNTS_LEN;
          end
          default: begin
            if (phase_r == PH_COUNTS && !fits) begin
              phase_nxt = PH_TRAILING;
              fstat_nxt = ST_TRUNCATED;
              st        = ST_TRUNCATED;
            end else begin
              for (int p = PH_TIMES; p <= PH_UTC; p++) begin
                sz = body_size(phase_t'(4'(p)), counts_nxt[CI_TIME], counts_nxt[CI_TYPE],
                               counts_nxt[CI_CHAR], counts_nxt[CI_LEAP],
                               counts_nxt[CI_STD], counts_nxt[CI_UTC], block_r);
                if (!found && 4'(p) > phase_r && sz != SIZE_W'(0)) begin
                  found     = 1'b1;
                  phase_nxt = phase_t'(4'(p));
                  rem_nxt   = sz;
                end
              end
              if (!found) begin
                if (!block_r && ver_nxt != VER_V1) begin
                  block_nxt = 1'b1;
                  phase_nxt = PH_MAGIC;
                  rem_nxt   = MAGIC_LEN;
                end else begin
                  phase_nxt = PH_TRAILING;
                  fstat_nxt = ST_COMPLETE;
                  st        = ST_COMPLETE;
                end
              end
            end
          end
        endcase
      end else begin
        rem_nxt = rem_r - SIZE_W'(1);
      end

      // Early end of file
      if (end_of_file && st == ST_RUNNING) begin
        st        = ST_TRUNCATED;
        phase_nxt = PH_TRAILING;
        fstat_nxt = ST_TRUNCATED;
      end
    end
    res.status = st;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      block_r <= 1'b0;
      ver_r   <= VER_V1;
      rem_r   <= MAGIC_LEN;
      fstat_r <= ST_RUNNING;
      for (int i = 0; i < NUM_COUNTS; i++) counts_r[i] <= count_t'(0);
    end else if (step) begin
      phase_r <= phase_nxt;
      block_r <= block_nxt;
      ver_r   <= ver_nxt;
      rem_r   <= rem_nxt;
      fstat_r <= fstat_nxt;
      for (int i = 0; i < NUM_COUNTS; i++) counts_r[i] <= counts_nxt[i];
    end
  end

  // Trailing is terminal, the second block is never left, and an
  // active section always has bytes left.
  `ASSERT_NXT(a_trail_sticky, phase_r == PH_TRAILING, phase_r == PH_TRAILING)
  `ASSERT_NXT(a_block_sticky, block_r, block_r)
  `ASSERT_IMP(a_rem_nonzero, phase_r != PH_TRAILING, rem_r != SIZE_W'(0))

endmodule

`default_nettype wire

// ===== src/tzsf_skid.sv =====
// ----------------------------------------------------------------------------
// tzsf_skid
// Output register plus one skid entry, so a new item is taken each cycle
// while the skid entry is empty, even when a finished result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tzsf_skid import tzsf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_item,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_item
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_r;
  result_t skid_r;
  logic    take;

  assign take      = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take || !out_valid_r) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (take || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : push_item;
    end else if (push) begin
      skid_r <= push_item;
    end
  end

  // Skid only fills behind a held output; a full skid drains to output.
  `ASSERT_IMP(a_skid_behind, skid_valid_r, out_valid_r)
  `ASSERT_NXT(a_skid_drain, skid_valid_r && !out_stall, out_valid_r && !skid_valid_r)

endmodule

`default_nettype wire

// ===== src/tzif_section_framer.sv =====
// Each accepted byte's result item is registered in the output buffer.
// Throughput: one byte per cycle while in_stall is low; framing decode is
// combinational, in front of a two-entry output buffer (output register plus
// skid entry). in_stall rises only when both output entries are held by
// out_stall. Reset (rst_n low, synchronous) returns framing to the magic
// section of the first block and empties the output buffer.
// ----------------------------------------------------------------------------
// tzif_section_framer
// Tags each byte of a time zone information file with its section, block,
// section end and parse status.
// ----------------------------------------------------------------------------
`default_nettype none

module tzif_section_framer import tzsf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_file,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte_out,
  output logic [3:0]      out_section,
  output logic            out_second_block,
  output logic            out_section_end,
  output logic [2:0]      out_status
);

  logic    step;
  logic    full;
  result_t res;
  result_t item;

  assign in_stall = full;
  assign step     = in_valid && !full;

  // Framing decode and state
  tzsf_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .data_byte   (in_data_byte),
    .end_of_file (in_end_of_file),
    .res         (res)
  );

  // Output buffering
  tzsf_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_item (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (item)
  );

  assign out_byte_out     = item.byte_out;
  assign out_section      = item.section;
  assign out_second_block = item.second_block;
  assign out_section_end  = item.section_end;
  assign out_status       = item.status;

endmodule

`default_nettype wire
